/* sv/grb_pkg.sv */
// ----------------------------------------------------------------------------
// grb_pkg
// Shared types and constants of the GPIO register block: word map, pin mode
// and pull codes, and the access and result records passed between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package grb_pkg;

    localparam int PAD_W         = 54;
    localparam int WORD_W        = 32;
    localparam int IDX_W         = 6;
    localparam int FSEL_WORDS    = 6;
    localparam int PINS_PER_FSEL = 10;
    localparam int MODE_W        = 3;
    localparam int FSEL_W        = PINS_PER_FSEL * MODE_W;
    localparam int PULL_W        = 2;
    localparam int WIDE_W        = 2 * WORD_W;

    // stream widths: tdata packed from the lowest bit, padded to whole bytes
    localparam int S_TDATA_BITS = IDX_W + WORD_W + PAD_W;
    localparam int S_TDATA_W    = ((S_TDATA_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = WORD_W + 4 * PAD_W;
    localparam int M_TDATA_W    = ((M_TDATA_BITS + 7) / 8) * 8;

    // word map
    localparam logic [IDX_W-1:0] REG_FSEL0     = 6'd0;
    localparam logic [IDX_W-1:0] REG_FSEL5     = 6'd5;
    localparam logic [IDX_W-1:0] REG_SET0      = 6'd7;
    localparam logic [IDX_W-1:0] REG_SET1      = 6'd8;
    localparam logic [IDX_W-1:0] REG_CLR0      = 6'd10;
    localparam logic [IDX_W-1:0] REG_CLR1      = 6'd11;
    localparam logic [IDX_W-1:0] REG_LEV0      = 6'd13;
    localparam logic [IDX_W-1:0] REG_LEV1      = 6'd14;
    localparam logic [IDX_W-1:0] REG_PULL_CTL  = 6'd37;
    localparam logic [IDX_W-1:0] REG_PULL_CLK0 = 6'd38;
    localparam logic [IDX_W-1:0] REG_PULL_CLK1 = 6'd39;

    localparam logic [MODE_W-1:0] MODE_OUTPUT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MASK   = 3'h7;
    localparam logic [PULL_W-1:0] PULL_MASK   = 2'h3;
    localparam logic [PULL_W-1:0] PULL_DOWN   = 2'd1;
    localparam logic [PULL_W-1:0] PULL_UP     = 2'd2;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef struct packed {
        logic              wr;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] data;
        logic [PAD_W-1:0]  pads;
    } grb_access_t;

    typedef struct packed {
        logic [PAD_W-1:0]  pull_down_en;
        logic [PAD_W-1:0]  pull_up_en;
        logic [PAD_W-1:0]  pad_enable;
        logic [PAD_W-1:0]  pad_out;
        logic [WORD_W-1:0] read_data;
    } grb_result_t;

    // mode bits of one function select word that belong to existing pins
    function automatic logic [FSEL_W-1:0] fsel_mask(input int word, input int num_pins);
        logic [FSEL_W-1:0] m;
        m = '0;
        for (int k = 0; k < PINS_PER_FSEL; k++)
        begin
            if (word * PINS_PER_FSEL + k < num_pins)
            begin
                m[k*MODE_W +: MODE_W] = MODE_MASK;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* sv/gpio_register_block.sv */
// ----------------------------------------------------------------------------
// gpio_register_block
// GPIO controller behind 32-bit word registers, one bus access per item.
//
//   channel | dir | tdata (low bit up)                       | tuser
//   s_*     | in  | reg_index, write_data, pad_in, zero pad  | func
//   m_*     | out | read_data, pad_out, pad_enable,          | -
//           |     | pull_up_en, pull_down_en                 |
//
// One item per cycle sustained while results are taken. An item is captured
// in the input register, then decoded and applied to the register state in
// one pass while moving into the result register. A stalled result holds
// both stages; s_tready stays high as long as the input stage can drain.
// Reset is asynchronous and clears all register state and both valid flags;
// no clearing pass follows.
// ----------------------------------------------------------------------------
`default_nettype none

module gpio_register_block
    import grb_pkg::*;
#(
    parameter int NUM_PINS = 54
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // reg_index, write_data, pad_in
    input  wire logic                 s_tuser,  // func
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // read_data, pad_out, pad_enable, pull_up_en, pull_down_en
    output logic [M_TDATA_W-1:0]      m_tdata
);

    grb_access_t in_reg;
    logic        in_valid_reg;
    grb_result_t out_reg;
    logic        out_valid_reg;
    grb_result_t res;
    logic        advance;
    logic        step;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload stages carry no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg.wr   <= s_tuser;
            in_reg.idx  <= s_tdata[IDX_W-1:0];
            in_reg.data <= s_tdata[IDX_W +: WORD_W];
            in_reg.pads <= s_tdata[IDX_W + WORD_W +: PAD_W];
        end
        if (step)
        begin
            out_reg <= res;
        end
    end

    grb_core #(
        .NUM_PINS (NUM_PINS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .acc   (in_reg),
        .res   (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_reg);

endmodule

`default_nettype wire

/* sv/grb_core.sv */
// ----------------------------------------------------------------------------
// grb_core
// Register state of the GPIO block and the single-pass access logic: decode
// one read or write, update the state and form the result word and pad view.
// ----------------------------------------------------------------------------
`default_nettype none

module grb_core
    import grb_pkg::*;
#(
    parameter int NUM_PINS = 54
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire grb_access_t acc,
    output grb_result_t      res
);

    logic [FSEL_W-1:0]   fsel_reg  [FSEL_WORDS];
    logic [FSEL_W-1:0]   fsel_next [FSEL_WORDS];
    logic [NUM_PINS-1:0] latch_reg;
    logic [NUM_PINS-1:0] latch_next;
    logic [PULL_W-1:0]   pctl_reg;
    logic [PULL_W-1:0]   pctl_next;
    logic [WORD_W-1:0]   pclk_reg  [2];
    logic [WORD_W-1:0]   pclk_next [2];
    logic [PULL_W-1:0]   pull_reg  [NUM_PINS];
    logic [PULL_W-1:0]   pull_next [NUM_PINS];

    logic [NUM_PINS-1:0] oe_cur;
    logic [NUM_PINS-1:0] oe_next;
    logic [NUM_PINS-1:0] up_next;
    logic [NUM_PINS-1:0] down_next;
    logic [NUM_PINS-1:0] pads_n;
    logic [NUM_PINS-1:0] level;
    logic [WIDE_W-1:0]   pads_wide;
    logic [WIDE_W-1:0]   level_wide;
    logic [WIDE_W-1:0]   data_wide;
    logic [NUM_PINS-1:0] data_pins;
    logic                hi_half;
    logic                pclk_wr;
    logic [WORD_W-1:0]   rd;
    logic [WIDE_W-1:0]   out_wide;
    logic [WIDE_W-1:0]   oe_wide;
    logic [WIDE_W-1:0]   up_wide;
    logic [WIDE_W-1:0]   down_wide;

    // pin modes; pins without a function select word stay inputs
    for (genvar p = 0; p < NUM_PINS; p++)
    begin : g_pin
        if (p / PINS_PER_FSEL < FSEL_WORDS)
        begin : g_mode
            assign oe_cur[p]  = fsel_reg[p / PINS_PER_FSEL]
                [(p % PINS_PER_FSEL) * MODE_W +: MODE_W] == MODE_OUTPUT;
            assign oe_next[p] = fsel_next[p / PINS_PER_FSEL]
                [(p % PINS_PER_FSEL) * MODE_W +: MODE_W] == MODE_OUTPUT;
        end
        else
        begin : g_input
            assign oe_cur[p]  = 1'b0;
            assign oe_next[p] = 1'b0;
        end
        assign up_next[p]   = pull_next[p] == PULL_UP;
        assign down_next[p] = pull_next[p] == PULL_DOWN;
    end

    assign hi_half   = (acc.idx == REG_SET1) || (acc.idx == REG_CLR1) ||
                       (acc.idx == REG_PULL_CLK1);
    assign data_wide = hi_half ? {acc.data, {WORD_W{1'b0}}} : {{WORD_W{1'b0}}, acc.data};
    assign data_pins = data_wide[NUM_PINS-1:0];

    assign pads_wide  = WIDE_W'(acc.pads);
    assign pads_n     = pads_wide[NUM_PINS-1:0];
    assign level      = (latch_reg & oe_cur) | (pads_n & ~oe_cur);
    assign level_wide = WIDE_W'(level);

    always_comb
    begin
        for (int w = 0; w < FSEL_WORDS; w++)
        begin
            fsel_next[w] = fsel_reg[w];
            if (acc.wr == FUNC_WRITE && acc.idx == IDX_W'(w))
            begin
                fsel_next[w] = acc.data[FSEL_W-1:0] & fsel_mask(w, NUM_PINS);
            end
        end
        latch_next   = latch_reg;
        pctl_next    = pctl_reg;
        pclk_next[0] = pclk_reg[0];
        pclk_next[1] = pclk_reg[1];
        pclk_wr      = 1'b0;
        rd           = '0;
        if (acc.wr == FUNC_WRITE)
        begin
            case (acc.idx) inside
                REG_SET0, REG_SET1:
                begin
                    latch_next = latch_reg | data_pins;
                end
                REG_CLR0, REG_CLR1:
                begin
                    latch_next = latch_reg & ~data_pins;
                end
                REG_PULL_CTL:
                begin
                    pctl_next = acc.data[PULL_W-1:0] & PULL_MASK;
                end
                REG_PULL_CLK0:
                begin
                    pclk_next[0] = acc.data;
                    pclk_wr      = 1'b1;
                end
                REG_PULL_CLK1:
                begin
                    pclk_next[1] = acc.data;
                    pclk_wr      = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            case (acc.idx) inside
                [REG_FSEL0:REG_FSEL5]:
                begin
                    rd = WORD_W'(fsel_reg[acc.idx[2:0]]);
                end
                REG_LEV0:
                begin
                    rd = level_wide[WORD_W-1:0];
                end
                REG_LEV1:
                begin
                    rd = level_wide[WIDE_W-1:WORD_W];
                end
                REG_PULL_CTL:
                begin
                    rd = WORD_W'(pctl_reg);
                end
                REG_PULL_CLK0:
                begin
                    rd = pclk_reg[0];
                end
                REG_PULL_CLK1:
                begin
                    rd = pclk_reg[1];
                end
                default:
                begin
                    rd = '0;
                end
            endcase
        end
        // latch the pull code into every pin selected by the clock word
        for (int p = 0; p < NUM_PINS; p++)
        begin
            pull_next[p] = pull_reg[p];
            if (pclk_wr && data_pins[p])
            begin
                pull_next[p] = pctl_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < FSEL_WORDS; w++)
            begin
                fsel_reg[w] <= '0;
            end
            latch_reg   <= '0;
            pctl_reg    <= '0;
            pclk_reg[0] <= '0;
            pclk_reg[1] <= '0;
            for (int p = 0; p < NUM_PINS; p++)
            begin
                pull_reg[p] <= '0;
            end
        end
        else if (step)
        begin
            fsel_reg    <= fsel_next;
            latch_reg   <= latch_next;
            pctl_reg    <= pctl_next;
            pclk_reg    <= pclk_next;
            pull_reg    <= pull_next;
        end
    end

    assign out_wide  = WIDE_W'(latch_next);
    assign oe_wide   = WIDE_W'(oe_next);
    assign up_wide   = WIDE_W'(up_next);
    assign down_wide = WIDE_W'(down_next);

    assign res.read_data    = rd;
    assign res.pad_out      = out_wide[PAD_W-1:0];
    assign res.pad_enable   = oe_wide[PAD_W-1:0];
    assign res.pull_up_en   = up_wide[PAD_W-1:0];
    assign res.pull_down_en = down_wide[PAD_W-1:0];

endmodule

`default_nettype wire

/* test/gpio_register_block_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gpio_register_block_test
// Drives bus reads and writes into the GPIO register block over its input
// stream and checks every result word against an in-bench model of the
// register state: function select, output latch, level readback and the
// pull control / pull clock latching. Both sides idle and stall at random.
// ----------------------------------------------------------------------------

module gpio_register_block_test;

    import grb_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 6;
    localparam int RANDOM_ITEMS    = 1600;
    localparam int DRAIN_EVERY     = 500;
    localparam int HOLDOFF_AT      = 300;
    localparam int HOLDOFF_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 10;
    localparam int MAX_REPORTS     = 10;

    // words with nothing behind them
    localparam logic [IDX_W-1:0] REG_HOLE    = 6'd6;
    localparam logic [IDX_W-1:0] REG_TOP     = 6'd63;
    localparam logic [IDX_W-1:0] REG_BEYOND  = 6'd40;

    localparam logic [WORD_W-1:0] ALL_ONES   = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] ALL_OUTPUT = 32'h0924_9249;
    localparam logic [PAD_W-1:0]  PADS_HIGH  = '1;
    localparam logic [PAD_W-1:0]  PADS_LOW   = '0;

    typedef struct {
        grb_access_t acc;
        bit          wait_idle;  // hold off until every result is back
    } bus_item_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    gpio_register_block dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_HALF) clk = ~clk;

    // register state as seen from the bus
    logic [FSEL_W-1:0] fsel_model [FSEL_WORDS];
    logic [PAD_W-1:0]  latch_model;
    logic [PULL_W-1:0] pull_code_model;
    logic [WORD_W-1:0] pull_clk_model [2];
    logic [PULL_W-1:0] pin_pull_model [PAD_W];

    bus_item_t   bus_accesses[$];
    grb_result_t predicted_results[$];
    bus_item_t   cur_item;

    int burst_left = 0;
    int gap_left = 0;
    int reads_sent = 0;
    int writes_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int stall_mode = 0;
    int stall_phase_left = 0;
    int holdoff_left = 0;
    bit holdoff_done = 1'b0;
    int idle_cycles = 0;

    function automatic logic [PAD_W-1:0] driven_pins();
        logic [PAD_W-1:0] m;
        m = '0;
        for (int p = 0; p < PAD_W; p++)
        begin
            if (fsel_model[p / PINS_PER_FSEL][(p % PINS_PER_FSEL) * MODE_W +: MODE_W]
                == MODE_OUTPUT)
                m[p] = 1'b1;
        end
        return m;
    endfunction

    // apply one bus access to the model and return the result it produces
    function automatic grb_result_t apply_access(grb_access_t a);
        grb_result_t       r;
        logic [PAD_W-1:0]  oe;
        logic [PAD_W-1:0]  level;
        logic [WIDE_W-1:0] wide;
        logic [WIDE_W-1:0] keep;
        int                npins;
        int                half;
        r = '0;
        oe = driven_pins();
        if (a.wr == FUNC_WRITE)
        begin
            if (a.idx <= REG_FSEL5)
            begin
                npins = PAD_W - int'(a.idx) * PINS_PER_FSEL;
                if (npins > PINS_PER_FSEL)
                    npins = PINS_PER_FSEL;
                keep = {WIDE_W{1'b1}} >> (WIDE_W - npins * MODE_W);
                fsel_model[a.idx] = a.data[FSEL_W-1:0] & keep[FSEL_W-1:0];
            end
            else
            begin
                wide = WIDE_W'(a.data);
                if (a.idx == REG_SET1 || a.idx == REG_CLR1)
                    wide = wide << WORD_W;
                case (a.idx)
                    REG_SET0, REG_SET1:
                        latch_model = latch_model | wide[PAD_W-1:0];
                    REG_CLR0, REG_CLR1:
                        latch_model = latch_model & ~wide[PAD_W-1:0];
                    REG_PULL_CTL:
                        pull_code_model = a.data[PULL_W-1:0];
                    REG_PULL_CLK0, REG_PULL_CLK1:
                    begin
                        half = (a.idx == REG_PULL_CLK1) ? 1 : 0;
                        pull_clk_model[half] = a.data;
                        for (int k = 0; k < WORD_W; k++)
                        begin
                            if (a.data[k] && half * WORD_W + k < PAD_W)
                                pin_pull_model[half * WORD_W + k] = pull_code_model;
                        end
                    end
                    default:
                        ;
                endcase
            end
        end
        else
        begin
            if (a.idx <= REG_FSEL5)
                r.read_data = WORD_W'(fsel_model[a.idx]);
            else
            begin
                case (a.idx)
                    REG_LEV0, REG_LEV1:
                    begin
                        level = (latch_model & oe) | (a.pads & ~oe);
                        wide = WIDE_W'(level);
                        r.read_data = (a.idx == REG_LEV1) ? wide[WIDE_W-1:WORD_W]
                                                          : wide[WORD_W-1:0];
                    end
                    REG_PULL_CTL:
                        r.read_data = WORD_W'(pull_code_model);
                    REG_PULL_CLK0:
                        r.read_data = pull_clk_model[0];
                    REG_PULL_CLK1:
                        r.read_data = pull_clk_model[1];
                    default:
                        r.read_data = '0;
                endcase
            end
        end
        r.pad_out = latch_model;
        r.pad_enable = driven_pins();
        for (int p = 0; p < PAD_W; p++)
        begin
            r.pull_up_en[p] = (pin_pull_model[p] == PULL_UP);
            r.pull_down_en[p] = (pin_pull_model[p] == PULL_DOWN);
        end
        return r;
    endfunction

    task automatic add_access(input logic wr, input logic [IDX_W-1:0] idx,
                              input logic [WORD_W-1:0] data,
                              input logic [PAD_W-1:0] pads, input bit wait_idle);
        bus_item_t it;
        it.acc.wr = wr;
        it.acc.idx = idx;
        it.acc.data = data;
        it.acc.pads = pads;
        it.wait_idle = wait_idle;
        bus_accesses.push_back(it);
    endtask

    function automatic logic [PAD_W-1:0] random_pads();
        logic [WIDE_W-1:0] r64;
        r64 = {$urandom(), $urandom()};
        case ($urandom_range(0, 7))
            0: return PADS_LOW;
            1: return PADS_HIGH;
            default: return r64[PAD_W-1:0];
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ALL_ONES;
            default: return $urandom();
        endcase
    endfunction

    // mostly output pins so that level reads and latch writes matter
    function automatic logic [WORD_W-1:0] random_fsel_word();
        logic [WORD_W-1:0] d;
        d = $urandom();
        for (int k = 0; k < PINS_PER_FSEL; k++)
        begin
            case ($urandom_range(0, 3))
                0, 1: d[k*MODE_W +: MODE_W] = MODE_OUTPUT;
                2: d[k*MODE_W +: MODE_W] = '0;
                default: ;
            endcase
        end
        return d;
    endfunction

    function automatic logic [IDX_W-1:0] random_index();
        logic [IDX_W-1:0] mapped [15];
        mapped = '{REG_FSEL0, REG_FSEL0 + 6'd1, REG_FSEL0 + 6'd2, REG_FSEL0 + 6'd3,
                   REG_FSEL0 + 6'd4, REG_FSEL5, REG_SET0, REG_SET1, REG_CLR0, REG_CLR1,
                   REG_LEV0, REG_LEV1, REG_PULL_CTL, REG_PULL_CLK0, REG_PULL_CLK1};
        if ($urandom_range(0, 99) < 85)
            return mapped[$urandom_range(0, 14)];
        return IDX_W'($urandom_range(0, 63));
    endfunction

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (mismatches < MAX_REPORTS)
            $display("mismatch on result %0d, %s: expected %h, got %h",
                     results_seen, field, want, got);
        mismatches++;
    endtask

    task automatic check_result();
        grb_result_t got;
        grb_result_t want;
        got = grb_result_t'(m_tdata[M_TDATA_BITS-1:0]);
        if (predicted_results.size() == 0)
        begin
            if (mismatches < MAX_REPORTS)
                $display("result %0d arrived with nothing outstanding", results_seen);
            mismatches++;
        end
        else
        begin
            want = predicted_results.pop_front();
            if (got.read_data !== want.read_data)
                note_mismatch("read_data", 64'(want.read_data), 64'(got.read_data));
            if (got.pad_out !== want.pad_out)
                note_mismatch("pad_out", 64'(want.pad_out), 64'(got.pad_out));
            if (got.pad_enable !== want.pad_enable)
                note_mismatch("pad_enable", 64'(want.pad_enable), 64'(got.pad_enable));
            if (got.pull_up_en !== want.pull_up_en)
                note_mismatch("pull_up_en", 64'(want.pull_up_en), 64'(got.pull_up_en));
            if (got.pull_down_en !== want.pull_down_en)
                note_mismatch("pull_down_en", 64'(want.pull_down_en),
                              64'(got.pull_down_en));
        end
        results_seen++;
    endtask

    // sender: bursts of items with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predicted_results.push_back(apply_access(cur_item.acc));
                if (cur_item.acc.wr == FUNC_WRITE)
                    writes_sent++;
                else
                    reads_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (bus_accesses.size() == 0)
                    s_tvalid <= 1'b0;
                else if (bus_accesses[0].wait_idle && predicted_results.size() != 0)
                    s_tvalid <= 1'b0;
                else
                begin
                    cur_item = bus_accesses.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= cur_item.acc.wr;
                    s_tdata <= S_TDATA_W'({cur_item.acc.pads, cur_item.acc.data,
                                           cur_item.acc.idx});
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
            end
        end
    end

    // receiver: stall pattern changes at random intervals, one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result();
            if (stall_phase_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_phase_left = $urandom_range(20, 80);
            end
            else
                stall_phase_left--;
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                m_tready <= 1'b0;
            end
            else if (!holdoff_done && results_seen >= HOLDOFF_AT)
            begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
                m_tready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 9) < 7);
                    2: m_tready <= ($urandom_range(0, 9) < 3);
                    default: m_tready <= !m_tready;
                endcase
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("no progress for %0d cycles, %0d results outstanding",
                         WATCHDOG_LIMIT, predicted_results.size());
                $display("gpio_register_block test failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [IDX_W-1:0]  idx;
        logic              wr;
        logic [WORD_W-1:0] data;

        for (int w = 0; w < FSEL_WORDS; w++)
            fsel_model[w] = '0;
        latch_model = '0;
        pull_code_model = '0;
        pull_clk_model[0] = '0;
        pull_clk_model[1] = '0;
        for (int p = 0; p < PAD_W; p++)
            pin_pull_model[p] = '0;

        // reset values, then mode bits of missing pins and the top two bits
        add_access(FUNC_READ, REG_FSEL0, ALL_ONES, PADS_HIGH, 1'b0);
        add_access(FUNC_READ, REG_LEV1, ALL_ONES, PADS_HIGH, 1'b0);
        add_access(FUNC_WRITE, REG_FSEL0, ALL_ONES, PADS_LOW, 1'b0);
        add_access(FUNC_READ, REG_FSEL0, '0, PADS_LOW, 1'b0);
        add_access(FUNC_WRITE, REG_FSEL5, ALL_ONES, PADS_LOW, 1'b0);
        add_access(FUNC_READ, REG_FSEL5, '0, PADS_LOW, 1'b0);
        // every pin an output, latch fully set, then partly cleared
        for (int w = 0; w < FSEL_WORDS; w++)
            add_access(FUNC_WRITE, REG_FSEL0 + IDX_W'(w), ALL_OUTPUT, PADS_LOW, 1'b0);
        add_access(FUNC_WRITE, REG_SET0, ALL_ONES, PADS_LOW, 1'b0);
        add_access(FUNC_WRITE, REG_SET1, ALL_ONES, PADS_LOW, 1'b0);
        add_access(FUNC_READ, REG_LEV1, '0, PADS_LOW, 1'b0);
        add_access(FUNC_WRITE, REG_CLR1, 32'h5555_5555, PADS_HIGH, 1'b0);
        add_access(FUNC_READ, REG_SET0, '0, PADS_HIGH, 1'b0);
        add_access(FUNC_READ, REG_CLR1, '0, PADS_HIGH, 1'b0);
        // inputs among outputs: level mixes pads and latch
        add_access(FUNC_WRITE, REG_FSEL0 + 6'd1, '0, PADS_HIGH, 1'b0);
        add_access(FUNC_WRITE, REG_CLR0, ALL_ONES, PADS_HIGH, 1'b0);
        add_access(FUNC_READ, REG_LEV0, '0, PADS_HIGH, 1'b0);
        // pull code 3 latches but enables nothing; up on the top half, down on the lowest sixteen pins
        add_access(FUNC_WRITE, REG_PULL_CTL, ALL_ONES, PADS_LOW, 1'b0);
        add_access(FUNC_WRITE, REG_PULL_CLK0, ALL_ONES, PADS_LOW, 1'b0);
        add_access(FUNC_READ, REG_PULL_CTL, '0, PADS_LOW, 1'b0);
        add_access(FUNC_WRITE, REG_PULL_CTL, WORD_W'(PULL_UP), PADS_LOW, 1'b0);
        add_access(FUNC_WRITE, REG_PULL_CLK1, ALL_ONES, PADS_LOW, 1'b0);
        add_access(FUNC_WRITE, REG_PULL_CTL, WORD_W'(PULL_DOWN), PADS_LOW, 1'b0);
        add_access(FUNC_WRITE, REG_PULL_CLK0, 32'h0000_FFFF, PADS_LOW, 1'b0);
        add_access(FUNC_READ, REG_PULL_CLK1, '0, PADS_LOW, 1'b0);
        // nothing mapped here
        add_access(FUNC_WRITE, REG_TOP, ALL_ONES, PADS_HIGH, 1'b0);
        add_access(FUNC_READ, REG_HOLE, ALL_ONES, PADS_HIGH, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // pull sequence: code, clock the pins in, release the clock word
            if ($urandom_range(0, 9) == 0)
            begin
                idx = ($urandom_range(0, 1) == 0) ? REG_PULL_CLK0 : REG_PULL_CLK1;
                add_access(FUNC_WRITE, REG_PULL_CTL, $urandom(), random_pads(),
                           (n % DRAIN_EVERY) == 0);
                add_access(FUNC_WRITE, idx, random_word(), random_pads(), 1'b0);
                add_access(FUNC_WRITE, idx, '0, random_pads(), 1'b0);
                n += 2;
            end
            else
            begin
                idx = random_index();
                wr = ($urandom_range(0, 99) < 55) ? FUNC_WRITE : FUNC_READ;
                data = (idx <= REG_FSEL5 && $urandom_range(0, 3) != 0)
                       ? random_fsel_word() : random_word();
                add_access(wr, idx, data, random_pads(), (n % DRAIN_EVERY) == 0);
            end
        end
        add_access(FUNC_READ, REG_BEYOND, '0, random_pads(), 1'b0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (bus_accesses.size() != 0 || s_tvalid)
            @(posedge clk);
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d accesses (%0d reads, %0d writes), %0d results checked,",
                 reads_sent + writes_sent, reads_sent, writes_sent, results_seen);
        $display("%0d mismatches, %0d results still outstanding",
                 mismatches, predicted_results.size());
        if (mismatches == 0 && predicted_results.size() == 0)
            $display("gpio_register_block test passed");
        else
            $display("gpio_register_block test failed");
        $finish;
    end

endmodule

/* sim.f */
sv/grb_pkg.sv
sv/grb_core.sv
sv/gpio_register_block.sv
test/gpio_register_block_test.sv
